### rtl/core/ttdg_pkg.sv
// Shared types, constants and the arctangent table for the goal steering unit.
`default_nettype none
package ttdg_pkg;

   localparam int COORD_W     = 16;
   localparam int DIFF_W      = 17;
   localparam int RADICAND_W  = 34;
   localparam int ROOT_W      = 17;
   localparam int VEC_W       = 32;
   localparam int ANGLE_W     = 34;
   localparam int ATAN_IDX_W  = 5;
   localparam int ATAN_ENTRIES = 24;

   localparam logic signed [COORD_W-1:0] GOAL_RESET  = 16'sd20480;
   localparam logic signed [COORD_W-1:0] GOAL_LIMIT  = 16'sd24576;
   localparam logic [15:0]               DIST_THR_RESET = 16'd205;
   localparam logic [14:0]               ANG_THR_RESET  = 15'd819;
   localparam logic signed [ANGLE_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [ANGLE_W-1:0] ROUND_HALF  = 34'sd131072;

   typedef enum logic {
      OP_POSE   = 1'b0,
      OP_TARGET = 1'b1
   } opcode_type;

   typedef enum logic {
      KIND_VELOCITY = 1'b0,
      KIND_TARGET   = 1'b1
   } result_kind_type;

   typedef enum logic {
      REG_DIST_THR = 1'b0,
      REG_ANG_THR  = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_LAUNCH,
      ST_RUN,
      ST_REPLY
   } state_type;

   // atan(2^-i) in Q30 radians
   function automatic logic signed [ANGLE_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [ANGLE_W-1:0] val;
      case (idx)
         5'd0:  val = 34'sd843314857;
         5'd1:  val = 34'sd497837829;
         5'd2:  val = 34'sd263043837;
         5'd3:  val = 34'sd133525159;
         5'd4:  val = 34'sd67021687;
         5'd5:  val = 34'sd33543516;
         5'd6:  val = 34'sd16775851;
         5'd7:  val = 34'sd8388437;
         5'd8:  val = 34'sd4194283;
         5'd9:  val = 34'sd2097149;
         5'd10: val = 34'sd1048576;
         5'd11: val = 34'sd524288;
         5'd12: val = 34'sd262144;
         5'd13: val = 34'sd131072;
         5'd14: val = 34'sd65536;
         5'd15: val = 34'sd32768;
         5'd16: val = 34'sd16384;
         5'd17: val = 34'sd8192;
         5'd18: val = 34'sd4096;
         5'd19: val = 34'sd2048;
         5'd20: val = 34'sd1024;
         5'd21: val = 34'sd512;
         5'd22: val = 34'sd256;
         5'd23: val = 34'sd128;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

### rtl/core/ttdg_isqrt.sv
// Digit-recurrence integer square root, one result bit per cycle.
`default_nettype none
module ttdg_isqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ttdg_pkg::RADICAND_W-1:0] radicand,
   output logic                            done,
   output logic [ttdg_pkg::ROOT_W-1:0]     root
);
   import ttdg_pkg::*;

   localparam logic [RADICAND_W-1:0] TOP_BIT = RADICAND_W'(1) << (RADICAND_W - 2);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [RADICAND_W-1:0] rem_ff, rem_in;
   logic [RADICAND_W-1:0] res_ff, res_in;
   logic [RADICAND_W-1:0] bit_ff, bit_in;
   logic [RADICAND_W:0]   trial;

   assign trial = {1'b0, res_ff} + {1'b0, bit_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         rem_in  = radicand;
         res_in  = '0;
         bit_in  = TOP_BIT;
      end else if (busy_ff) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in = rem_ff - trial[RADICAND_W-1:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         // finish after the units bit
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[ROOT_W-1:0];

endmodule
`default_nettype wire

### rtl/core/ttdg_cordic.sv
// Iterative vectoring CORDIC that yields the bearing of a difference vector.
`default_nettype none
module ttdg_cordic #(
   parameter int ITERATIONS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [ttdg_pkg::DIFF_W-1:0] dx,
   input  logic signed [ttdg_pkg::DIFF_W-1:0] dy,
   output logic                               done,
   output logic signed [ttdg_pkg::COORD_W-1:0] bearing
);
   import ttdg_pkg::*;

   localparam int STEPS = (ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : ITERATIONS;
   localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic signed [VEC_W-1:0]   x_ff, x_in;
   logic signed [VEC_W-1:0]   y_ff, y_in;
   logic signed [ANGLE_W-1:0] z_ff, z_in;
   logic signed [VEC_W-1:0]   x_pre, y_pre, xs, ys;
   logic signed [ANGLE_W-1:0] z_round;

   // scale by 2^12 into the vector width
   assign x_pre = {{(VEC_W-DIFF_W-12){dx[DIFF_W-1]}}, dx, 12'b0};
   assign y_pre = {{(VEC_W-DIFF_W-12){dy[DIFF_W-1]}}, dy, 12'b0};
   assign xs    = x_ff >>> cnt_ff;
   assign ys    = y_ff >>> cnt_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         x_in    = x_pre;
         y_in    = y_pre;
         z_in    = '0;
         // rotate a left half plane vector by a quarter turn
         if (dx[DIFF_W-1]) begin
            if (!dy[DIFF_W-1]) begin
               x_in = y_pre;
               y_in = -x_pre;
               z_in = HALF_PI_Q30;
            end else begin
               x_in = -y_pre;
               y_in = x_pre;
               z_in = -HALF_PI_Q30;
            end
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_q30(ATAN_IDX_W'(cnt_ff));
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_q30(ATAN_IDX_W'(cnt_ff));
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   // round Q30 to Q4.12
   assign z_round = z_ff + ROUND_HALF;
   assign bearing = z_round[ANGLE_W-1:ANGLE_W-COORD_W];
   assign done    = done_ff;

endmodule
`default_nettype wire

### rtl/core/turn_then_drive_goal_steering_unit.sv
// Top level of the turn-then-drive go-to-goal steering unit.
`default_nettype none
// The unit keeps a goal position (Q5.11, reset 10.0, 10.0) and answers one word on the
// response channel for every word on the request channel. A target request (opcode 1)
// replaces the goal when both coordinates are non-zero and below 12.0, and answers with
// accepted set or clear. A pose sample (opcode 0) forms the distance to the goal with an
// exact digit-recurrence square root and the bearing with an iterative vectoring
// CORDIC, then emits stop, turn-in-place (angular speed = bearing error, saturated) or
// drive-straight (linear speed = distance, saturated). A pose passes from acceptance
// through squaring of dx then dy in one 17x17 multiplier, a launch state, 17 square-root
// steps and the CORDIC steps side by side (CORDIC_ITERATIONS of them, capped at 24), the
// forming of the command, the hand-off to the output register and the return to idle,
// where the next word is taken. The hand-off waits while the output register still
// holds an untaken word. The request side is ready only while idle; the output register
// holds a finished word while the next request is taken. Thresholds live at byte 0
// (distance, 16 bits) and byte 4 (angle, 15 bits) of the configuration port and should
// be written only while the unit is idle.
module turn_then_drive_goal_steering_unit #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic signed [15:0] req_x_value,
   input  logic signed [15:0] req_y_value,
   input  logic signed [15:0] req_heading,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic        rsp_accepted,
   output logic [15:0] rsp_linear_speed,
   output logic signed [15:0] rsp_angular_speed,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ttdg_pkg::*;

   // ---------------------------------------------------------------- state
   state_type                  state_ff, state_in;
   logic [15:0]                dist_thr_ff, dist_thr_in;
   logic [14:0]                ang_thr_ff, ang_thr_in;
   logic signed [COORD_W-1:0]  goal_x_ff, goal_x_in;
   logic signed [COORD_W-1:0]  goal_y_ff, goal_y_in;
   logic signed [DIFF_W-1:0]   dx_ff, dx_in;
   logic signed [DIFF_W-1:0]   dy_ff, dy_in;
   logic signed [COORD_W-1:0]  hd_ff, hd_in;
   logic [RADICAND_W-1:0]      sq_ff, sq_in;

   // held result, waiting for the output register
   logic                       hold_kind_ff, hold_kind_in;
   logic                       hold_ok_ff, hold_ok_in;
   logic [15:0]                hold_lin_ff, hold_lin_in;
   logic signed [15:0]         hold_ang_ff, hold_ang_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_kind_ff, rsp_kind_in;
   logic                       rsp_ok_ff, rsp_ok_in;
   logic [15:0]                rsp_lin_ff, rsp_lin_in;
   logic signed [15:0]         rsp_ang_ff, rsp_ang_in;

   // ---------------------------------------------------------------- control
   logic req_fire, cfg_write, slot_free, units_done;
   logic launch, sq_first, sq_second, capture_pose, capture_target, emit;
   logic target_ok;
   reg_index_type cfg_index;

   assign req_fire  = req_valid && req_ready;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_index = reg_index_type'(csr_paddr[2]);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------------- datapath units
   logic signed [DIFF_W-1:0]     mul_op;
   logic signed [2*DIFF_W-1:0]   mul_prod;
   logic                         root_done, cordic_done;
   logic [ROOT_W-1:0]            root;
   logic signed [COORD_W-1:0]    bearing;

   // one multiplier squares dx then dy
   assign mul_op   = sq_second ? dy_ff : dx_ff;
   assign mul_prod = mul_op * mul_op;

   ttdg_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (launch),
      .radicand (sq_ff),
      .done     (root_done),
      .root     (root)
   );

   ttdg_cordic #(
      .ITERATIONS (CORDIC_ITERATIONS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (launch),
      .dx      (dx_ff),
      .dy      (dy_ff),
      .done    (cordic_done),
      .bearing (bearing)
   );

   assign units_done = root_done && cordic_done;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (opcode_type'(req_opcode) == OP_TARGET) ? ST_REPLY : ST_SQ_X;
            end
         end
         ST_SQ_X:   state_in = ST_SQ_Y;
         ST_SQ_Y:   state_in = ST_LAUNCH;
         ST_LAUNCH: state_in = ST_RUN;
         ST_RUN: begin
            if (units_done) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- state outputs
   always_comb begin
      req_ready      = 1'b0;
      sq_first       = 1'b0;
      sq_second      = 1'b0;
      launch         = 1'b0;
      capture_pose   = 1'b0;
      emit           = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready    = 1'b1;
         ST_SQ_X:   sq_first     = 1'b1;
         ST_SQ_Y:   sq_second    = 1'b1;
         ST_LAUNCH: launch       = 1'b1;
         ST_RUN:    capture_pose = units_done;
         ST_REPLY:  emit         = slot_free;
         default:   req_ready    = 1'b0;
      endcase
   end

   assign capture_target = req_fire && (opcode_type'(req_opcode) == OP_TARGET);

   // ---------------------------------------------------------------- goal and operands
   // accept a goal coordinate only when non-zero and below 12.0
   assign target_ok = (req_x_value != '0) && (req_x_value < GOAL_LIMIT) &&
                      (req_y_value != '0) && (req_y_value < GOAL_LIMIT);

   always_comb begin
      goal_x_in = goal_x_ff;
      goal_y_in = goal_y_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      hd_in     = hd_ff;
      sq_in     = sq_ff;
      if (capture_target && target_ok) begin
         goal_x_in = req_x_value;
         goal_y_in = req_y_value;
      end
      if (req_fire) begin
         dx_in = {goal_x_ff[COORD_W-1], goal_x_ff} - {req_x_value[COORD_W-1], req_x_value};
         dy_in = {goal_y_ff[COORD_W-1], goal_y_ff} - {req_y_value[COORD_W-1], req_y_value};
         hd_in = req_heading;
      end
      // squares are never negative
      if (sq_first) begin
         sq_in = $unsigned(mul_prod);
      end else if (sq_second) begin
         sq_in = sq_ff + $unsigned(mul_prod);
      end
   end

   // ---------------------------------------------------------------- steering decision
   logic signed [DIFF_W-1:0] err;
   logic                     stop_cmd, turn_cmd;
   logic [15:0]              lin_sat;
   logic signed [15:0]       ang_sat;

   assign err      = {bearing[COORD_W-1], bearing} - {hd_ff[COORD_W-1], hd_ff};
   assign stop_cmd = root <= {1'b0, dist_thr_ff};
   assign turn_cmd = err > $signed({2'b00, ang_thr_ff});
   // err is above a non-negative threshold here, so only the top needs clipping
   assign ang_sat  = (err > 17'sd32767) ? 16'sh7fff : err[15:0];
   assign lin_sat  = root[ROOT_W-1] ? 16'hffff : root[15:0];

   always_comb begin
      hold_kind_in = hold_kind_ff;
      hold_ok_in   = hold_ok_ff;
      hold_lin_in  = hold_lin_ff;
      hold_ang_in  = hold_ang_ff;
      if (capture_target) begin
         hold_kind_in = KIND_TARGET;
         hold_ok_in   = target_ok;
         hold_lin_in  = '0;
         hold_ang_in  = '0;
      end else if (capture_pose) begin
         hold_kind_in = KIND_VELOCITY;
         hold_ok_in   = 1'b1;
         hold_lin_in  = '0;
         hold_ang_in  = '0;
         if (!stop_cmd) begin
            if (turn_cmd) begin
               hold_ang_in = ang_sat;
            end else begin
               hold_lin_in = lin_sat;
            end
         end
      end
   end

   // ---------------------------------------------------------------- output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_lin_in   = rsp_lin_ff;
      rsp_ang_in   = rsp_ang_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = hold_kind_ff;
         rsp_ok_in    = hold_ok_ff;
         rsp_lin_in   = hold_lin_ff;
         rsp_ang_in   = hold_ang_ff;
      end else if (rsp_ready) begin
         // drop the word once taken
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------- configuration
   always_comb begin
      dist_thr_in = dist_thr_ff;
      ang_thr_in  = ang_thr_ff;
      if (cfg_write) begin
         case (cfg_index)
            REG_DIST_THR: dist_thr_in = csr_pwdata[15:0];
            REG_ANG_THR:  ang_thr_in  = csr_pwdata[14:0];
            default:      dist_thr_in = dist_thr_ff;
         endcase
      end
   end

   always_comb begin
      case (cfg_index)
         REG_DIST_THR: csr_prdata = {16'b0, dist_thr_ff};
         REG_ANG_THR:  csr_prdata = {17'b0, ang_thr_ff};
         default:      csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dist_thr_ff  <= DIST_THR_RESET;
         ang_thr_ff   <= ANG_THR_RESET;
         goal_x_ff    <= GOAL_RESET;
         goal_y_ff    <= GOAL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dist_thr_ff  <= dist_thr_in;
         ang_thr_ff   <= ang_thr_in;
         goal_x_ff    <= goal_x_in;
         goal_y_ff    <= goal_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      hd_ff        <= hd_in;
      sq_ff        <= sq_in;
      hold_kind_ff <= hold_kind_in;
      hold_ok_ff   <= hold_ok_in;
      hold_lin_ff  <= hold_lin_in;
      hold_ang_ff  <= hold_ang_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_lin_ff   <= rsp_lin_in;
      rsp_ang_ff   <= rsp_ang_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = rsp_kind_ff;
   assign rsp_accepted      = rsp_ok_ff;
   assign rsp_linear_speed  = rsp_lin_ff;
   assign rsp_angular_speed = rsp_ang_ff;

   // ---------------------------------------------------------------- assertions
   // a valid target request lands in the goal registers
   a_goal_update: assert property (@(posedge clock) disable iff (reset)
      (capture_target && target_ok) |=>
         (goal_x_ff == $past(req_x_value) && goal_y_ff == $past(req_y_value)))
      else $error("goal not updated by a valid target request");

   // a launch clears both unit done flags
   a_launch_clears: assert property (@(posedge clock) disable iff (reset)
      launch |=> (!root_done && !cordic_done))
      else $error("iterative units report done right after launch");

   // within the stop radius both speeds are zero
   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      (capture_pose && stop_cmd) |=> (hold_lin_ff == '0 && hold_ang_ff == '0))
      else $error("nonzero speed inside the stop radius");

   // never turn and drive at once
   a_one_motion: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_lin_ff == '0 || rsp_ang_ff == '0))
      else $error("both linear and angular speed set");

endmodule
`default_nettype wire

### verif/ttdg_command_checker.sv
// Checker that predicts every steering unit response word and compares it with the output.
module ttdg_command_checker #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_opcode,
   input  logic signed [15:0] req_x_value,
   input  logic signed [15:0] req_y_value,
   input  logic signed [15:0] req_heading,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_result_kind,
   input  logic        rsp_accepted,
   input  logic [15:0] rsp_linear_speed,
   input  logic signed [15:0] rsp_angular_speed,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   output int          pending_words,
   output int          mismatch_total
);
   timeunit 1ns;
   timeprecision 1ps;
   import ttdg_pkg::*;

   localparam int ROTATIONS = (CORDIC_ITERATIONS > 24) ? 24 : CORDIC_ITERATIONS;
   localparam int HOME_Q511 = 20480;
   localparam int GOAL_CEILING = 24576;
   localparam int STOP_RADIUS_AT_RESET = 205;
   localparam int TURN_LIMIT_AT_RESET = 819;
   localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;

   typedef struct packed {
      logic              kind;
      logic              accepted;
      logic [15:0]       linear;
      logic signed [15:0] angular;
   } steer_word_type;

   steer_word_type expected_commands[$];
   int goal_x;
   int goal_y;
   int stop_radius;
   int turn_limit;
   int backlog = 0;
   int mismatches = 0;

   assign pending_words  = backlog;
   assign mismatch_total = mismatches;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // atan(2^-step) in Q30 radians
   function automatic longint micro_angle(input int step);
      case (step)
         0:  return 64'sd843314857;
         1:  return 64'sd497837829;
         2:  return 64'sd263043837;
         3:  return 64'sd133525159;
         4:  return 64'sd67021687;
         5:  return 64'sd33543516;
         6:  return 64'sd16775851;
         7:  return 64'sd8388437;
         8:  return 64'sd4194283;
         9:  return 64'sd2097149;
         10: return 64'sd1048576;
         11: return 64'sd524288;
         12: return 64'sd262144;
         13: return 64'sd131072;
         14: return 64'sd65536;
         15: return 64'sd32768;
         16: return 64'sd16384;
         17: return 64'sd8192;
         18: return 64'sd4096;
         19: return 64'sd2048;
         20: return 64'sd1024;
         21: return 64'sd512;
         22: return 64'sd256;
         23: return 64'sd128;
         default: return 64'sd0;
      endcase
   endfunction

   function automatic longint floor_root(input longint radicand);
      longint rem;
      longint root;
      longint probe;
      rem   = radicand;
      root  = 0;
      probe = 64'sd1 <<< 62;
      while (probe > rem)
         probe = probe >>> 2;
      while (probe != 0) begin
         if (rem >= root + probe) begin
            rem  = rem - (root + probe);
            root = (root >>> 1) + probe;
         end else begin
            root = root >>> 1;
         end
         probe = probe >>> 2;
      end
      return root;
   endfunction

   // vectoring rotation: angle of (dx, dy) in Q4.12 radians
   function automatic int bearing_q12(input int dx, input int dy);
      longint vx;
      longint vy;
      longint ang;
      longint sx;
      longint sy;
      longint held;
      int     step;
      if (dx == 0 && dy == 0)
         return 0;
      vx  = longint'(dx) * 4096;
      vy  = longint'(dy) * 4096;
      ang = 0;
      // fold the left half plane over by a quarter turn
      if (vx < 0) begin
         held = vx;
         if (vy >= 0) begin
            vx  = vy;
            vy  = -held;
            ang = QUARTER_TURN_Q30;
         end else begin
            vx  = -vy;
            vy  = held;
            ang = -QUARTER_TURN_Q30;
         end
      end
      for (step = 0; step < ROTATIONS; step++) begin
         sx = vx >>> step;
         sy = vy >>> step;
         if (vy > 0) begin
            vx  = vx + sy;
            vy  = vy - sx;
            ang = ang + micro_angle(step);
         end else begin
            vx  = vx - sy;
            vy  = vy + sx;
            ang = ang - micro_angle(step);
         end
      end
      return int'((ang + (64'sd1 <<< 17)) >>> 18);
   endfunction

   function automatic steer_word_type steer_command(input int px, input int py, input int ph);
      steer_word_type cmd;
      int             dx;
      int             dy;
      int             err;
      longint         span;
      dx   = goal_x - px;
      dy   = goal_y - py;
      span = floor_root(longint'(dx) * dx + longint'(dy) * dy);
      err  = bearing_q12(dx, dy) - ph;
      cmd.kind     = KIND_VELOCITY;
      cmd.accepted = 1'b1;
      cmd.linear   = '0;
      cmd.angular  = '0;
      if (span > stop_radius) begin
         if (err > turn_limit)
            cmd.angular = (err > 32767) ? 16'sh7FFF : err[15:0];
         else
            cmd.linear = (span > 65535) ? 16'hFFFF : span[15:0];
      end
      return cmd;
   endfunction

   always @(posedge clock) begin
      steer_word_type want;
      logic           goal_ok;
      longint         reg_value;
      if (reset) begin
         goal_x      = HOME_Q511;
         goal_y      = HOME_Q511;
         stop_radius = STOP_RADIUS_AT_RESET;
         turn_limit  = TURN_LIMIT_AT_RESET;
         expected_commands.delete();
      end else begin
         // results first: a word leaving at this edge belongs to an earlier request
         if (rsp_valid && rsp_ready) begin
            if (expected_commands.size() == 0) begin
               report_mismatch("response with nothing expected, kind", rsp_result_kind, -1);
            end else begin
               want = expected_commands.pop_front();
               if (rsp_result_kind !== want.kind)
                  report_mismatch("result_kind", rsp_result_kind, want.kind);
               if (rsp_accepted !== want.accepted)
                  report_mismatch("accepted", rsp_accepted, want.accepted);
               if (rsp_linear_speed !== want.linear)
                  report_mismatch("linear_speed", rsp_linear_speed, want.linear);
               if (rsp_angular_speed !== want.angular)
                  report_mismatch("angular_speed", rsp_angular_speed, want.angular);
            end
         end
         if (req_valid && req_ready) begin
            if (req_opcode == OP_TARGET) begin
               goal_ok = (req_x_value != 0) && (req_x_value < GOAL_CEILING) &&
                         (req_y_value != 0) && (req_y_value < GOAL_CEILING);
               if (goal_ok) begin
                  goal_x = req_x_value;
                  goal_y = req_y_value;
               end
               want.kind     = KIND_TARGET;
               want.accepted = goal_ok;
               want.linear   = '0;
               want.angular  = '0;
            end else begin
               want = steer_command(req_x_value, req_y_value, req_heading);
            end
            expected_commands.push_back(want);
         end
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[2] == REG_DIST_THR)
                  stop_radius = csr_pwdata[15:0];
               else
                  turn_limit = csr_pwdata[14:0];
            end else begin
               reg_value = (csr_paddr[2] == REG_DIST_THR) ? stop_radius : turn_limit;
               if (csr_prdata !== reg_value[31:0])
                  report_mismatch("register readback", csr_prdata, reg_value);
            end
         end
      end
      backlog <= expected_commands.size();
   end

endmodule

### verif/tb_turn_then_drive_goal_steering_unit.sv
// Testbench top: stimulus, register setup and verdict for the goal steering unit.
module tb_turn_then_drive_goal_steering_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import ttdg_pkg::*;

   localparam int CORDIC_ITERATIONS = 16;
   // budget for the ~850 words, taken several times over
   localparam int CYCLE_LIMIT     = 500000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int PHASE_COUNT     = 8;
   localparam int WORDS_PER_PHASE = 100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_opcode = OP_POSE;
   logic signed [15:0] req_x_value = '0;
   logic signed [15:0] req_y_value = '0;
   logic signed [15:0] req_heading = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_result_kind;
   logic        rsp_accepted;
   logic [15:0] rsp_linear_speed;
   logic signed [15:0] rsp_angular_speed;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int pending_words;
   int mismatch_total;
   int cycle_count = 0;
   // idle mix of the current phase, in percent
   int gap_pct = 0;
   int stall_pct = 0;
   // where the goal should sit now, used only to aim poses near it
   int aim_x = 20480;
   int aim_y = 20480;

   turn_then_drive_goal_steering_unit #(
      .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_x_value      (req_x_value),
      .req_y_value      (req_y_value),
      .req_heading      (req_heading),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_accepted     (rsp_accepted),
      .rsp_linear_speed (rsp_linear_speed),
      .rsp_angular_speed(rsp_angular_speed),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   ttdg_command_checker #(
      .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
   ) u_command_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_x_value      (req_x_value),
      .req_y_value      (req_y_value),
      .req_heading      (req_heading),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_accepted     (rsp_accepted),
      .rsp_linear_speed (rsp_linear_speed),
      .rsp_angular_speed(rsp_angular_speed),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready),
      .pending_words    (pending_words),
      .mismatch_total   (mismatch_total)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Receiver: drop ready on a random share of cycles, per the phase's stall rate.
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Offer one request word and hold it until the unit takes it. A random idle gap
   // may come first; valid is raised or kept high only once per edge.
   task automatic send_word(input opcode_type op, input int x, input int y, input int h);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_x_value <= x[15:0];
      req_y_value <= y[15:0];
      req_heading <= h[15:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the write lands at the access edge. The bus returns
   // to idle before the next transfer.
   task automatic write_register(input reg_index_type idx, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_register(input reg_index_type idx);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Hold off until every expected word has come back: the unit is idle then.
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
   endtask

   // Coordinate that the unit accepts as a goal: non-zero and below 12.0, either sign.
   function automatic int goal_coord();
      if ($urandom_range(0, 1))
         return int'($urandom_range(1, 24575));
      return -int'($urandom_range(1, 32768));
   endfunction

   // Point within spread of centre, clipped to the Q5.11 range.
   function automatic int near(input int centre, input int spread);
      int v;
      v = centre + int'($urandom_range(0, 2 * spread)) - spread;
      if (v > 32767)
         v = 32767;
      if (v < -32768)
         v = -32768;
      return v;
   endfunction

   // Mostly poses around the current goal so stop, turn and drive all occur; some
   // target requests, most of them good so the goal keeps moving.
   task automatic random_word();
      int x;
      int y;
      int h;
      if ($urandom_range(0, 99) < 15) begin
         if ($urandom_range(0, 4) != 0) begin
            x = goal_coord();
            y = goal_coord();
            aim_x = x;
            aim_y = y;
         end else begin
            x = int'($urandom_range(0, 65535)) - 32768;
            y = int'($urandom_range(0, 65535)) - 32768;
            case ($urandom_range(0, 3))
               0: x = 0;
               1: y = 0;
               2: x = 24576 + int'($urandom_range(0, 8191));
               default: y = 24576 + int'($urandom_range(0, 8191));
            endcase
         end
         send_word(OP_TARGET, x, y, int'($urandom_range(0, 65535)) - 32768);
      end else begin
         case ($urandom_range(0, 2))
            0: begin
               x = int'($urandom_range(0, 65535)) - 32768;
               y = int'($urandom_range(0, 65535)) - 32768;
            end
            1: begin
               x = near(aim_x, 400);
               y = near(aim_y, 400);
            end
            default: begin
               x = near(aim_x, 8000);
               y = near(aim_y, 8000);
            end
         endcase
         if ($urandom_range(0, 1))
            h = int'($urandom_range(0, 65535)) - 32768;
         else
            h = int'($urandom_range(0, 26000)) - 13000;
         send_word(OP_POSE, x, y, h);
      end
   endtask

   initial begin
      int phase;
      int item;
      int dist_thr;
      int ang_thr;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      fork
         begin
            // Directed words at reset thresholds, goal at (10.0, 10.0).
            send_word(OP_POSE, 20480, 20480, 0);             // zero vector: stop
            send_word(OP_POSE, 20480 - 205, 20480, 0);       // distance equals threshold
            send_word(OP_POSE, 20480 - 206, 20480, 0);       // just past it: drive
            send_word(OP_POSE, -32768, -32768, 3217);        // far away: linear saturates
            send_word(OP_POSE, -32768, -32768, -32768);      // huge error: angular saturates
            send_word(OP_POSE, 20480, 0, 32767);             // negative error drives
            send_word(OP_POSE, 32767, 20480, 0);             // goal straight behind
            send_word(OP_POSE, 32767, 32767, 0);             // third quadrant
            send_word(OP_POSE, 0, 0, -32768);
            send_word(OP_TARGET, 0, 100, 0);                 // zero x: reject
            send_word(OP_TARGET, 100, 0, 0);                 // zero y: reject
            send_word(OP_TARGET, 24576, 100, 0);             // exactly 12.0: reject
            send_word(OP_TARGET, 100, 24576, 0);
            send_word(OP_TARGET, 32767, -32768, 32767);      // top of the range: reject
            send_word(OP_TARGET, -32768, -32768, 0);         // negative goal is taken
            send_word(OP_POSE, -32768, -32768, 0);           // sitting on it: stop
            send_word(OP_POSE, 32767, 32767, 0);             // longest vector
            send_word(OP_TARGET, 24575, 24575, -32768);      // largest goal taken
            send_word(OP_TARGET, 1, -1, 0);
            send_word(OP_POSE, 1, -1, 0);
            send_word(OP_POSE, -32768, 32767, 12000);
            send_word(OP_TARGET, 20480, 20480, 0);
            aim_x = 20480;
            aim_y = 20480;

            // Random phases: each one retunes the thresholds while idle, then
            // runs under one of the idle mixes.
            for (phase = 0; phase < PHASE_COUNT; phase++) begin
               drain_responses();
               case (phase)
                  0: begin dist_thr = 0;     ang_thr = 0;     end
                  1: begin dist_thr = 65535; ang_thr = 32767; end
                  2: begin dist_thr = 205;   ang_thr = 819;   end
                  4: begin dist_thr = 0;     ang_thr = 32767; end
                  5: begin dist_thr = 65535; ang_thr = 0;     end
                  6: begin
                     dist_thr = $urandom_range(0, 2000);
                     ang_thr  = $urandom_range(0, 4000);
                  end
                  default: begin
                     dist_thr = $urandom_range(0, 65535);
                     ang_thr  = $urandom_range(0, 32767);
                  end
               endcase
               // junk in the unused upper bits must be dropped by the unit
               write_register(REG_DIST_THR, ($urandom & 32'hFFFF_0000) | dist_thr);
               write_register(REG_ANG_THR, ($urandom & 32'hFFFF_8000) | ang_thr);
               read_register(REG_DIST_THR);
               read_register(REG_ANG_THR);
               case (phase % 4)
                  0: begin gap_pct = 0;  stall_pct = 0;  end
                  1: begin gap_pct = 60; stall_pct = 0;  end
                  2: begin gap_pct = 0;  stall_pct = 60; end
                  default: begin gap_pct = 12; stall_pct = 12; end
               endcase
               for (item = 0; item < WORDS_PER_PHASE; item++)
                  random_word();
            end
            drain_responses();
            repeat (SETTLE_CYCLES) @(posedge clock);
         end
         wait (cycle_count >= CYCLE_LIMIT);
      join_any
      disable fork;
      // a timeout leaves words outstanding and counts as a failure
      if (cycle_count >= CYCLE_LIMIT || mismatch_total != 0) begin
         $display("turn_then_drive_goal_steering_unit regression: fail");
      end else begin
         $display("turn_then_drive_goal_steering_unit regression: pass");
      end
      $finish;
   end

endmodule
